[src/crc16_frame_checker_assert.svh]
// ============================================================================
// CRC-16 frame checker assertion macros
// Shared assertion forms for the frame checker, clocked on aclk and
// disabled while aresetn is low.
// ============================================================================
`ifndef CRC16_FRAME_CHECKER_ASSERT_SVH
`define CRC16_FRAME_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRC16FC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRC16FC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/crc16fc_pkg.sv]
// ============================================================================
// CRC-16 frame checker package
// Types, codes and the CRC-16/MODBUS byte update shared by the checker.
// ============================================================================
package crc16fc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_STOP_MARKER  = 2'd1,
        CFG_PAYLOAD_LEN  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_START    = 3'd1,
        ST_LEN_MISMATCH = 3'd2,
        ST_CRC_MISMATCH = 3'd3,
        ST_BAD_STOP     = 3'd4,
        ST_SHORT        = 3'd5
    } status_t;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_LEN_LO  = 8'b0000_0010,
        PH_LEN_HI  = 8'b0000_0100,
        PH_PAYLOAD = 8'b0000_1000,
        PH_CRC_LO  = 8'b0001_0000,
        PH_CRC_HI  = 8'b0010_0000,
        PH_STOP    = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  stop_marker;
        logic [15:0] expected_payload_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        status_t    frame_status;
    } result_t;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[src/crc16_frame_checker.sv]
// ============================================================================
// CRC-16 framed datagram checker
// Checks start byte, length, CRC-16/MODBUS and stop byte of byte-serial frames.
// ============================================================================
// The block takes one byte per clock cycle with no gaps of its own: a byte is
// parsed in the cycle it is accepted and its result item, if any, appears on
// the m_ channel at the next clock edge. A result item is given for every
// payload byte and for every byte that ends a datagram; other bytes give none.
// The only limit on rate is the single result register: while it holds an
// item that has not been taken, s_ready follows m_ready.
// ============================================================================
module crc16_frame_checker import crc16fc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_datagram,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_payload_valid,
    output logic        m_frame_done,
    output logic [2:0]  m_frame_status
);

    cfg_t    cfg;
    logic    accept;
    logic    has_result;
    result_t result;
    result_t m_result;

    assign accept = s_valid & s_ready;

    crc16fc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc16fc_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .accept          (accept),
        .rx_byte         (s_rx_byte),
        .end_of_datagram (s_end_of_datagram),
        .has_result      (has_result),
        .result          (result)
    );

    crc16fc_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .has_result (has_result),
        .result     (result),
        .take_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    assign m_payload_byte  = m_result.payload_byte;
    assign m_payload_valid = m_result.payload_valid;
    assign m_frame_done    = m_result.frame_done;
    assign m_frame_status  = m_result.frame_status;

endmodule

[src/crc16fc_cfg.sv]
// ============================================================================
// CRC-16 frame checker configuration registers
// Holds the start marker, stop marker and expected payload length.
// ============================================================================
module crc16fc_cfg import crc16fc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_MARKER: cfg_next.start_marker         = cfg_data[7:0];
                CFG_STOP_MARKER:  cfg_next.stop_marker          = cfg_data[7:0];
                CFG_PAYLOAD_LEN:  cfg_next.expected_payload_len = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_marker         <= 8'hAA;
            cfg_reg.stop_marker          <= 8'h55;
            cfg_reg.expected_payload_len <= 16'h0000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[src/crc16fc_core.sv]
// ============================================================================
// CRC-16 frame checker parser
// Frame state machine with running CRC; decides each item's result.
// ============================================================================
module crc16fc_core import crc16fc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       end_of_datagram,
    output logic       has_result,
    output result_t    result
);

    `include "crc16_frame_checker_assert.svh"

    phase_t      phase_reg, phase_next;
    logic [15:0] position_reg, position_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    status_t     error_reg, error_next;

    logic [15:0] crc_step;
    logic [16:0] position_sum;

    assign crc_step     = crc16_update(crc_reg, rx_byte);
    assign position_sum = {1'b0, position_reg} + 17'd1;

    always_comb begin
        phase_next      = phase_reg;
        position_next   = position_reg;
        length_low_next = length_low_reg;
        crc_next        = crc_reg;
        crc_low_next    = crc_low_reg;
        error_next      = error_reg;
        result          = '{payload_byte: 8'h00, payload_valid: 1'b0,
                            frame_done: 1'b0, frame_status: ST_OK};

        if (error_reg == ST_OK) begin
            unique case (phase_reg)
                PH_START: begin
                    if (rx_byte != cfg.start_marker) begin
                        error_next = ST_BAD_START;
                    end else begin
                        phase_next = PH_LEN_LO;
                    end
                end
                PH_LEN_LO: begin
                    length_low_next = rx_byte;
                    crc_next        = crc_step;
                    phase_next      = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    crc_next = crc_step;
                    if ({rx_byte, length_low_reg} != cfg.expected_payload_len) begin
                        error_next = ST_LEN_MISMATCH;
                    end else begin
                        position_next = 16'h0000;
                        phase_next    = (cfg.expected_payload_len == 16'h0000)
                                        ? PH_CRC_LO : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    crc_next             = crc_step;
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    position_next        = position_sum[15:0];
                    if (position_sum >= {1'b0, cfg.expected_payload_len}) begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    crc_low_next = rx_byte;
                    phase_next   = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    if ({rx_byte, crc_low_reg} != crc_reg) begin
                        error_next = ST_CRC_MISMATCH;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
                PH_STOP: begin
                    if (rx_byte != cfg.stop_marker) begin
                        error_next = ST_BAD_STOP;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
        end

        if (end_of_datagram) begin
            result.frame_done = 1'b1;
            if (error_next != ST_OK) begin
                result.frame_status = error_next;
            end else if (phase_next == PH_DONE) begin
                result.frame_status = ST_OK;
            end else begin
                result.frame_status = ST_SHORT;
            end
            phase_next      = PH_START;
            position_next   = 16'h0000;
            length_low_next = 8'h00;
            crc_next        = CRC_INIT;
            crc_low_next    = 8'h00;
            error_next      = ST_OK;
        end

        has_result = result.payload_valid | result.frame_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            position_reg   <= 16'h0000;
            length_low_reg <= 8'h00;
            crc_reg        <= CRC_INIT;
            crc_low_reg    <= 8'h00;
            error_reg      <= ST_OK;
        end else if (accept) begin
            phase_reg      <= phase_next;
            position_reg   <= position_next;
            length_low_reg <= length_low_next;
            crc_reg        <= crc_next;
            crc_low_reg    <= crc_low_next;
            error_reg      <= error_next;
        end
    end

    `CRC16FC_ASSERT_NEXT(a_clear_after_end, accept && end_of_datagram, phase_reg == PH_START && error_reg == ST_OK && crc_reg == CRC_INIT, "Frame state not cleared after datagram end.")
    `CRC16FC_ASSERT_SAME(a_ok_needs_done, result.frame_done && result.frame_status == ST_OK, error_reg == ST_OK && (phase_reg == PH_DONE || phase_reg == PH_STOP), "Good status without a complete frame.")
    `CRC16FC_ASSERT_SAME(a_payload_phase, result.payload_valid, phase_reg == PH_PAYLOAD && error_reg == ST_OK, "Payload item outside the payload phase.")

endmodule

[src/crc16fc_out_reg.sv]
// ============================================================================
// CRC-16 frame checker result register
// Holds one result item until the downstream side takes it.
// ============================================================================
module crc16fc_out_reg import crc16fc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    accept,
    input  logic    has_result,
    input  result_t result,
    output logic    take_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg, valid_next;
    result_t result_reg;

    assign take_ready = ~valid_reg | m_ready;
    assign m_valid    = valid_reg;
    assign m_result   = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take_ready) begin
            valid_next = accept & has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && has_result) begin
            result_reg <= result;
        end
    end

endmodule
